### src/kmp_pkg.sv
// Shared types, constants and helpers for the Keccak multi-rate padder.
// No dependencies; every other file imports this package.
package kmp_pkg;

   // Rate limits and reset value (bits)
   localparam int MAX_RATE_BITS_DEF = 1600;
   localparam int RATE_MIN = 3;
   localparam logic [10:0] RATE_RESET = 11'd1088;

   // Padding phase
   typedef enum logic [1:0] {
      PH_READY   = 2'd0,
      PH_STARTED = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   // Input beat
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [10:0] used_bits;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       block_produced;
      logic       last_of_block;
      logic       range_error;
   } rsp_type;

   // Per-beat status handed from the pad logic to the phase control
   typedef struct packed {
      logic last;
      logic err;
      logic one_left;
   } stat_type;

   // Clamp a written rate into [RATE_MIN, max_rate]
   function automatic logic [10:0] sat_rate(input logic [10:0] r, input logic [10:0] max_rate);
      logic [10:0] v;
      v = r;
      if (v < 11'(RATE_MIN)) v = 11'(RATE_MIN);
      if (v > max_rate) v = max_rate;
      return v;
   endfunction

endpackage

### src/kmp_pad_logic.sv
// Combinational pad10*1 byte logic: forms one padded byte from the registered beat.
// Depends on kmp_pkg.
module kmp_pad_logic
   import kmp_pkg::*;
#(
   parameter int POS_W = 8
) (
   input  req_type     req,
   input  logic [10:0] rate,
   input  phase_type   phase,
   input  logic [POS_W-1:0] pos,
   output rsp_type     rsp,
   output stat_type    stat,
   output logic [POS_W-1:0] pos_next
);

   logic [10:0]      rate_m1;
   logic [7:0]       nb;
   logic [POS_W-1:0] pos_e;
   logic [7:0]       pos_x;
   logic [7:0]       lb;
   logic [2:0]       bits;
   logic [7:0]       end_bit;
   logic [7:0]       part_byte;
   logic [7:0]       ob;
   logic             produced;
   logic             last;
   logic             err;
   logic             one_left;

   // Block geometry and message split
   always_comb begin
      rate_m1  = rate - 11'd1;
      nb       = 8'((rate + 11'd7) >> 3);
      pos_e    = (8'(pos) >= nb) ? '0 : pos;
      pos_x    = 8'(pos_e);
      last     = (pos_x == (nb - 8'd1));
      err      = (req.used_bits >= rate);
      lb       = req.used_bits[10:3];
      bits     = req.used_bits[2:0];
      one_left = ((req.used_bits + 11'd1) == rate);
      end_bit  = 8'd1 << rate_m1[2:0];
      // shift the partial byte down; a full shift of eight clears it
      part_byte = (req.data_byte >> (4'd8 - {1'b0, bits})) | (8'd1 << bits);
   end

   // Byte selection by phase
   always_comb begin
      ob       = req.data_byte;
      produced = 1'b0;
      if (!err) begin
         unique case (phase)
            PH_DONE: begin
               ob       = req.data_byte;
               produced = 1'b0;
            end
            PH_STARTED: begin
               ob       = last ? end_bit : 8'd0;
               produced = 1'b1;
            end
            default: begin
               priority if (pos_x < lb) begin
                  ob = req.data_byte;
               end else if (pos_x == lb) begin
                  ob = part_byte;
               end else begin
                  ob = 8'd0;
               end
               if (last && !one_left) ob = ob | end_bit;
               produced = 1'b1;
            end
         endcase
      end
   end

   // Drive result and status
   always_comb begin
      rsp.out_byte       = ob;
      rsp.block_produced = produced;
      rsp.last_of_block  = last;
      rsp.range_error    = err;
      stat.last          = last;
      stat.err           = err;
      stat.one_left      = one_left;
      pos_next           = last ? '0 : (pos_e + POS_W'(1));
   end

endmodule

### src/keccak_multirate_padder.sv
// Top level of the Keccak pad10*1 multi-rate padder: input register, pad logic,
// result register, phase control. Depends on kmp_pkg and kmp_pad_logic.
//
// The padder takes one byte of the final message block per beat and returns one padded
// byte per beat. It accepts a beat every cycle while results are taken; results are
// registered: the beat is captured in the input register when it is accepted and its
// padded byte in the result register once the result slot is free. While a result waits,
// the input register still takes one more beat before the input side stalls. The block
// is ceil(rate/8) bytes long; last_of_block marks its final byte, and the phase (ready,
// started, done) advances only after that byte. Write csr_wdata with csr_we to set the
// rate (clamped to 3..MAX_RATE_BITS); a write also restarts the byte position.
// Write the rate only while no beat is in flight.
module keccak_multirate_padder
   import kmp_pkg::*;
#(
   parameter int MAX_RATE_BITS = MAX_RATE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);

   localparam int NB_MAX = (MAX_RATE_BITS + 7) / 8;
   localparam int POS_W = $clog2(NB_MAX + 1);
   localparam logic [10:0] MAX_RATE = 11'(MAX_RATE_BITS);
   localparam logic [10:0] RATE_INIT = sat_rate(RATE_RESET, MAX_RATE);

   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic [10:0]      rate_ff, rate_in;
   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             s1_adv;
   rsp_type          rsp_calc;
   stat_type         stat;
   logic [POS_W-1:0] pos_next;

   // Handshake: move the registered beat on when the result slot is free
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   kmp_pad_logic #(
      .POS_W (POS_W)
   ) u_pad (
      .req      (s1_data_ff),
      .rate     (rate_ff),
      .phase    (phase_ff),
      .pos      (pos_ff),
      .rsp      (rsp_calc),
      .stat     (stat),
      .pos_next (pos_next)
   );

   // Next phase: change only after a clean last byte
   always_comb begin
      phase_in = phase_ff;
      if (s1_adv && stat.last && !stat.err) begin
         unique case (phase_ff)
            PH_STARTED: phase_in = PH_DONE;
            PH_DONE:    phase_in = PH_READY;
            default:    phase_in = stat.one_left ? PH_STARTED : PH_DONE;
         endcase
      end
   end

   // Next values of the pipeline, position and rate
   always_comb begin
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rate_in      = csr_we ? sat_rate(csr_wdata, MAX_RATE) : rate_ff;
      priority if (csr_we) begin
         pos_in = '0;
      end else if (s1_adv) begin
         pos_in = pos_next;
      end else begin
         pos_in = pos_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_INIT;
         phase_ff     <= PH_READY;
         pos_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload registers: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) s1_data_ff <= req_data;
      if (s1_adv) rsp_data_ff <= rsp_calc;
   end

   // Position always stays inside the current block
   a_pos_in_block: assert property (@(posedge clock) disable iff (reset)
      ((11'(pos_ff) + 11'd1) <= ((rate_ff + 11'd7) >> 3)))
      else $error("byte position outside block");

   // Effective rate stays within its clamp
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      (rate_ff >= 11'(RATE_MIN)) && (rate_ff <= MAX_RATE))
      else $error("rate outside clamp range");

   // Phase holds unless a last byte moves on
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      (!(s1_adv && stat.last)) |=> $stable(phase_ff))
      else $error("phase changed mid-block");

   // Rate write restarts the block
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (pos_ff == '0))
      else $error("position not cleared by rate write");

endmodule

### tb/keccak_multirate_padder_tb.sv
// Self-checking bench for keccak_multirate_padder: pad10*1 results per byte beat,
// predicted in-bench and compared in order. Depends on kmp_pkg and the padder RTL.
module keccak_multirate_padder_tb;
   import kmp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int NUM_RATE_STEPS = 13;

   // Padder state as seen from outside: rate register, phase, byte position
   typedef struct packed {
      logic [10:0] rate;
      phase_type   phase;
      logic [7:0]  pos;
   } pad_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   req_type       bytes_to_send[$];
   rsp_type       pending_padded[$];
   pad_state_type dut_shadow;
   pad_state_type plan_shadow;
   rsp_type       want_rsp;
   logic          idle_en = 1'b1;
   int unsigned   send_gap = 0;
   int unsigned   rsp_stall = 0;
   int unsigned   mismatches = 0;
   int unsigned   cycles = 0;

   keccak_multirate_padder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Clamp the rate register to the usable range
   function automatic int unsigned sponge_rate(input logic [10:0] r);
      int unsigned v;
      v = r;
      if (v < RATE_MIN) v = RATE_MIN;
      if (v > MAX_RATE_BITS_DEF) v = MAX_RATE_BITS_DEF;
      return v;
   endfunction

   // Pad one byte beat and advance the phase and byte position
   function automatic rsp_type pad_byte(inout pad_state_type st, input req_type beat);
      int unsigned r, nb, pos, used, lb, nbits;
      logic [7:0]  end_bit, ob;
      logic        last, err, one_left, made;
      phase_type   nxt;
      rsp_type     res;
      r = sponge_rate(st.rate);
      nb = (r + 7) / 8;
      pos = st.pos;
      if (pos >= nb) pos = 0;
      used = beat.used_bits;
      last = (pos == nb - 1);
      err = (used >= r);
      end_bit = 8'(1 << ((r - 1) % 8));
      ob = beat.data_byte;
      made = 1'b0;
      nxt = st.phase;
      if (!err) begin
         unique case (st.phase)
            PH_DONE: begin
               nxt = PH_READY;
            end
            PH_STARTED: begin
               ob = last ? end_bit : 8'h00;
               made = 1'b1;
               nxt = PH_DONE;
            end
            default: begin
               lb = used / 8;
               nbits = used % 8;
               one_left = (used + 1 == r);
               // keep message bytes, shift the partial byte down, clear the tail
               if (pos > lb)
                  ob = 8'h00;
               else if (pos == lb)
                  ob = ((nbits == 0) ? 8'h00 : 8'(beat.data_byte >> (8 - nbits)))
                       | 8'(1 << nbits);
               if (last && !one_left) ob = ob | end_bit;
               made = 1'b1;
               nxt = one_left ? PH_STARTED : PH_DONE;
            end
         endcase
      end
      if (last) begin
         if (!err) st.phase = nxt;
         st.pos = 8'd0;
      end else begin
         st.pos = 8'(pos + 1);
      end
      res.out_byte = ob;
      res.block_produced = made;
      res.last_of_block = last;
      res.range_error = err;
      return res;
   endfunction

   // Queue one byte beat and track where the padder will stand after it
   task automatic queue_beat(input logic [7:0] d, input logic [10:0] u);
      req_type beat;
      beat.data_byte = d;
      beat.used_bits = u;
      bytes_to_send.push_back(beat);
      void'(pad_byte(plan_shadow, beat));
   endtask

   // Message length for a fresh final block; favor the one-bit-of-room case
   function automatic int unsigned pick_ready_used(input int unsigned r);
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 25) return r - 1;
      if (k < 35) return 0;
      if (k < 45) return r - 2;
      if (k < 60) return 8 * $urandom_range(0, (r - 2) / 8);
      return $urandom_range(0, r - 2);
   endfunction

   // Queue whole blocks that follow the phase sequence, with some error
   // blocks and blocks of mixed lengths mixed in
   task automatic queue_traffic(input int unsigned n_items);
      int unsigned r, kind, used, sent;
      logic [10:0] u;
      sent = 0;
      while (sent < n_items) begin
         r = sponge_rate(plan_shadow.rate);
         kind = $urandom_range(0, 99);
         if (plan_shadow.phase == PH_READY)
            used = pick_ready_used(r);
         else
            used = $urandom_range(0, r - 1);
         if (kind < 7) used = $urandom_range(r, 2047);
         do begin
            u = 11'(used);
            if (kind >= 93)
               u = $urandom_range(0, 1) ? 11'($urandom_range(0, 2047))
                                        : 11'($urandom_range(0, r - 1));
            queue_beat(8'($urandom_range(0, 255)), u);
            sent++;
         end while (plan_shadow.pos != 0 && sent < n_items);
      end
   endtask

   // Wait until nothing is queued, on the bus or owed by the padder
   task automatic wait_drain();
      while (bytes_to_send.size() != 0 || req_valid || pending_padded.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the rate once the padder is idle; this also restarts the byte position
   task automatic write_rate(input logic [10:0] v);
      wait_drain();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      dut_shadow.rate = v;
      dut_shadow.pos = 8'd0;
      plan_shadow.rate = v;
      plan_shadow.pos = 8'd0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Driver: score the beat taken at this edge, then hold or present the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            pending_padded.push_back(pad_byte(dut_shadow, req_data));
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(0, 16);
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               req_data <= bytes_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest expectation, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_padded.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result beat: out_byte %h produced %b last %b err %b",
                           rsp_data.out_byte, rsp_data.block_produced,
                           rsp_data.last_of_block, rsp_data.range_error);
               mismatches++;
            end else begin
               want_rsp = pending_padded.pop_front();
               if (rsp_data.out_byte !== want_rsp.out_byte ||
                   rsp_data.block_produced !== want_rsp.block_produced ||
                   rsp_data.last_of_block !== want_rsp.last_of_block ||
                   rsp_data.range_error !== want_rsp.range_error) begin
                  if (mismatches < 10)
                     $display({"result beat differs: expected out_byte %h produced %b ",
                               "last %b err %b, got out_byte %h produced %b last %b err %b"},
                              want_rsp.out_byte, want_rsp.block_produced,
                              want_rsp.last_of_block, want_rsp.range_error,
                              rsp_data.out_byte, rsp_data.block_produced,
                              rsp_data.last_of_block, rsp_data.range_error);
                  mismatches++;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 11) == 0) begin
            rsp_stall = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("keccak_multirate_padder: mismatch");
         $finish;
      end
   end

   initial begin
      logic [10:0] step_rate [0:NUM_RATE_STEPS-1];
      int unsigned step_items;
      step_rate = '{11'd1, 11'd4, 11'd7, 11'd8, 11'd9, 11'd12, 11'd16, 11'd23,
                    11'd40, 11'd64, 11'd100, 11'd2047, 11'd3};
      dut_shadow = '{RATE_RESET, PH_READY, 8'd0};
      plan_shadow = dut_shadow;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Smallest rate, one-byte blocks: plain pad, pass-through, one bit of room,
      // end-bit-only block, out-of-range lengths
      write_rate(11'd0);
      queue_beat(8'hFF, 11'd0);
      queue_beat(8'hA5, 11'd1);
      queue_beat(8'h00, 11'd2);
      queue_beat(8'hFF, 11'd0);
      queue_beat(8'h3C, 11'd0);
      queue_beat(8'hFF, 11'd3);
      queue_beat(8'h00, 11'd2047);
      queue_beat(8'hFF, 11'd1);
      queue_beat(8'h12, 11'd0);

      // Two-byte blocks, one bit of room spilling into the started block
      write_rate(11'd16);
      queue_beat(8'hFF, 11'd15);
      queue_beat(8'hFF, 11'd15);
      queue_beat(8'hAA, 11'd0);
      queue_beat(8'h55, 11'd0);
      queue_beat(8'hAA, 11'd0);
      queue_beat(8'h55, 11'd0);

      // Rate not a multiple of eight: end bit in bit 0 of a short last byte
      write_rate(11'd9);
      queue_beat(8'hF0, 11'd7);
      queue_beat(8'h0F, 11'd7);
      queue_beat(8'h00, 11'd8);
      queue_beat(8'h00, 11'd8);

      // Random traffic over a range of rates; the last steps run without idling
      for (int p = 0; p < NUM_RATE_STEPS; p++) begin
         idle_en = (p < NUM_RATE_STEPS - 2) && (p != 4);
         write_rate(step_rate[p]);
         step_items = (step_rate[p] > 11'd1000) ? 400 : 85;
         if (p == 6) begin
            // hold the sender until every result is back, mid-stream
            queue_traffic(step_items / 2);
            wait_drain();
            queue_traffic(step_items - step_items / 2);
         end else begin
            queue_traffic(step_items);
         end
      end

      wait_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_padded.size() == 0)
         $display("keccak_multirate_padder: match");
      else
         $display("keccak_multirate_padder: mismatch");
      $finish;
   end

endmodule
